// ----- rtl/dq_pkg.sv -----
package dq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP_FWD   = 3'd4,
    REQ_DUMP_BWD   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } st_e;

  // circular slot of base + off, both below DEPTH
  function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] base,
                                              input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

endpackage

// ----- rtl/double_ended_queue.sv -----
// push, empty pop and empty dump: result beat registered the cycle after the input beat
// pop: read into rd_data_q, then the output registers; dump: the first entry likewise,
// then one entry per cycle while out_ready_i is high
// throughput: one push per cycle while out_ready_i is high; a pop or dump holds
// in_ready_o low until its last entry is loaded into the output registers
// reset: asynchronous, active low; the queue comes up empty, stored values are undefined
module double_ended_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          req_type_i,
  input  logic signed [31:0]  item_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  out_value_o,
  output logic                last_o
);

  localparam int unsigned IW = dq_pkg::IW;
  localparam int unsigned CW = dq_pkg::CW;
  localparam int unsigned DW = dq_pkg::DW;

  logic [DW-1:0] entry_mem_q [dq_pkg::DEPTH];
  logic [DW-1:0] rd_data_q;

  dq_pkg::st_e     state_q, state_d;
  logic [IW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   total_q, total_d;
  logic [CW-1:0]   issued_q, issued_d;
  logic            dir_bwd_q, dir_bwd_d;
  logic            rd_pend_q, rd_pend_d;
  logic            rd_last_q, rd_last_d;
  logic            out_valid_q, out_valid_d;

  dq_pkg::status_e status_q, status_d;
  logic [DW-1:0]   out_value_q, out_value_d;
  logic            last_q, last_d;

  logic            wr_en, rd_en;
  logic [IW-1:0]   wr_addr, rd_addr;
  logic            out_free, out_load, load_from_mem;
  dq_pkg::status_e load_status;
  logic            is_empty, is_full;
  logic [CW-1:0]   back_off, stream_off;

  assign out_free   = !out_valid_q || out_ready_i;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CW'(dq_pkg::DEPTH));
  assign back_off   = count_q - CW'(1);
  assign stream_off = dir_bwd_q ? (total_q - CW'(1) - issued_q) : issued_q;

  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    count_d       = count_q;
    total_d       = total_q;
    issued_d      = issued_q;
    dir_bwd_d     = dir_bwd_q;
    rd_pend_d     = rd_pend_q;
    rd_last_d     = rd_last_q;
    out_load      = 1'b0;
    load_from_mem = 1'b0;
    load_status   = dq_pkg::STAT_OK;
    wr_en         = 1'b0;
    wr_addr       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      dq_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          case (req_type_i)
            dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
              out_load = 1'b1;
              if (is_full) begin
                load_status = dq_pkg::STAT_FULL;
              end else begin
                wr_en = 1'b1;
                if (req_type_i == dq_pkg::REQ_PUSH_BACK) begin
                  wr_addr = dq_pkg::wrap_slot(front_q, count_q[IW-1:0]);
                end else begin
                  wr_addr = dq_pkg::wrap_slot(front_q, IW'(dq_pkg::DEPTH - 1));
                  front_d = wr_addr;
                end
                count_d = count_q + CW'(1);
              end
            end
            dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                out_load    = 1'b1;
                load_status = dq_pkg::STAT_EMPTY;
              end else begin
                rd_en = 1'b1;
                if (req_type_i == dq_pkg::REQ_POP_FRONT) begin
                  rd_addr = front_q;
                  front_d = dq_pkg::wrap_slot(front_q, IW'(1));
                end else begin
                  rd_addr = dq_pkg::wrap_slot(front_q, back_off[IW-1:0]);
                end
                count_d   = count_q - CW'(1);
                total_d   = CW'(1);
                issued_d  = CW'(1);
                rd_pend_d = 1'b1;
                rd_last_d = 1'b1;
                state_d   = dq_pkg::ST_STREAM;
              end
            end
            dq_pkg::REQ_DUMP_FWD, dq_pkg::REQ_DUMP_BWD: begin
              if (is_empty) begin
                out_load    = 1'b1;
                load_status = dq_pkg::STAT_EMPTY;
              end else begin
                rd_en = 1'b1;
                if (req_type_i == dq_pkg::REQ_DUMP_FWD) begin
                  rd_addr = front_q;
                end else begin
                  rd_addr = dq_pkg::wrap_slot(front_q, back_off[IW-1:0]);
                end
                total_d   = count_q;
                issued_d  = CW'(1);
                dir_bwd_d = (req_type_i == dq_pkg::REQ_DUMP_BWD);
                rd_pend_d = 1'b1;
                rd_last_d = (count_q == CW'(1));
                state_d   = dq_pkg::ST_STREAM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dq_pkg::ST_STREAM: begin
        if (rd_pend_q && out_free) begin
          out_load      = 1'b1;
          load_from_mem = 1'b1;
          rd_pend_d     = 1'b0;
          if (rd_last_q) begin
            state_d = dq_pkg::ST_IDLE;
          end
        end
        if ((issued_q != total_q) && (!rd_pend_q || out_free)) begin
          rd_en     = 1'b1;
          rd_addr   = dq_pkg::wrap_slot(front_q, stream_off[IW-1:0]);
          issued_d  = issued_q + CW'(1);
          rd_pend_d = 1'b1;
          rd_last_d = ((issued_q + CW'(1)) == total_q);
        end
      end
      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_value_d = out_value_q;
    last_d      = last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      status_d    = load_status;
      out_value_d = load_from_mem ? rd_data_q : '0;
      last_d      = load_from_mem ? rd_last_q : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      total_q     <= '0;
      issued_q    <= '0;
      dir_bwd_q   <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      total_q     <= total_d;
      issued_q    <= issued_d;
      dir_bwd_q   <= dir_bwd_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    out_value_q <= out_value_d;
    last_q      <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= item_value_i;
    end
    if (rd_en) begin
      rd_data_q <= entry_mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule
